[rtl/cpio_pkg.sv]
// ----------------------------------------------------------------------------
// cpio_pkg
// Shared constants, types and helper functions of the cpio stream parser.
// ----------------------------------------------------------------------------
package cpio_pkg;

	localparam int MAX_NAME_BYTES = 256;
	localparam int NAME_CNT_W = $clog2(MAX_NAME_BYTES + 1);
	localparam logic [6:0] HDR_BYTES = 7'd110;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] KIND_NAME = 2'd0;
	localparam logic [1:0] KIND_COMMIT = 2'd1;
	localparam logic [1:0] KIND_CONTENT = 2'd2;
	localparam logic [1:0] KIND_FINISH = 2'd3;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD_HEX = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC = 3'd2;
	localparam logic [2:0] ST_NAME_LONG = 3'd3;
	localparam logic [2:0] ST_NAME_BAD = 3'd4;
	localparam logic [2:0] ST_TRUNC = 3'd5;
	localparam logic [2:0] ST_TOO_LARGE = 3'd6;

	// All results caused by one input item.
	typedef struct packed {
		logic        byte_v;
		logic        is_content;
		logic        commit_v;
		logic        finish_v;
		logic [7:0]  data;
		logic [31:0] size;
		logic [2:0]  status;
	} run_t;

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
			(b >= 8'h61 && b <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_value(input logic [7:0] b);
		logic [7:0] v;
		if (b >= 8'h61) begin
			v = b - 8'h57;
		end else if (b >= 8'h41) begin
			v = b - 8'h37;
		end else begin
			v = b - 8'h30;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] magic_char(input logic [2:0] i);
		case (i)
			3'd1, 3'd3: return 8'h37;
			3'd5:       return 8'h32;
			default:    return 8'h30;
		endcase
	endfunction

	function automatic logic [7:0] trailer_char(input logic [3:0] i);
		case (i)
			4'd0:             return 8'h54;
			4'd1:             return 8'h52;
			4'd2:             return 8'h41;
			4'd3:             return 8'h49;
			4'd4:             return 8'h4C;
			4'd5:             return 8'h45;
			4'd6:             return 8'h52;
			4'd7, 4'd8, 4'd9: return 8'h21;
			default:          return 8'h00;
		endcase
	endfunction

endpackage

[rtl/cpio_front.sv]
// ----------------------------------------------------------------------------
// cpio_front
// Takes one archive byte per cycle while take is high, tracks the record
// structure and builds the set of results that the byte causes.
// ----------------------------------------------------------------------------
module cpio_front
	import cpio_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  archive_byte,
	input  logic [31:0] archive_length,
	output run_t        run,
	output logic        run_v
);

	localparam logic [2:0] PH_HEADER = 3'd0;
	localparam logic [2:0] PH_NAME = 3'd1;
	localparam logic [2:0] PH_NAMEPAD = 3'd2;
	localparam logic [2:0] PH_CONTENT = 3'd3;
	localparam logic [2:0] PH_CONTENTPAD = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	logic [2:0]            phase_q, phase_d;
	logic [31:0]           pos_q, pos_d;
	logic [6:0]            idx_q, idx_d;
	logic [31:0]           nsz_q, nsz_d;
	logic [31:0]           fsz_q, fsz_d;
	logic                  magic_q, magic_d;
	logic [NAME_CNT_W-1:0] ncnt_q, ncnt_d;
	logic                  trl_q, trl_d;
	logic [31:0]           left_q, left_d;
	logic                  fin_q, fin_d;

	logic [32:0] len33;
	logic [32:0] algn;
	logic [32:0] room;
	logic [31:0] room32;
	logic [31:0] pos_n;

	assign len33 = {1'b0, archive_length};

	// Finishing status at the start of the next record: bit 3 set means
	// another record follows.
	function automatic logic [3:0] rec_end(input logic [32:0] nxt, input logic [32:0] len);
		logic [32:0] diff;
		diff = len - nxt;
		if (nxt >= len) begin
			return {1'b0, ST_OK};
		end else if (diff < 33'(HDR_BYTES)) begin
			return {1'b0, ST_TRUNC};
		end
		return {1'b1, ST_OK};
	endfunction

	logic [3:0] re;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		idx_d = idx_q;
		nsz_d = nsz_q;
		fsz_d = fsz_q;
		magic_d = magic_q;
		ncnt_d = ncnt_q;
		trl_d = trl_q;
		left_d = left_q;
		fin_d = fin_q;
		run = '0;
		run.data = archive_byte;
		pos_n = pos_q + 32'd1;
		algn = ({1'b0, pos_n} + 33'd3) & ~33'd3;
		room = (algn > len33) ? 33'd0 : len33 - algn;
		room32 = (pos_n > archive_length) ? 32'd0 : archive_length - pos_n;
		re = rec_end(algn, len33);
		if (!fin_q) begin
			case (phase_q)
				PH_HEADER: begin
					if (idx_q == 7'd0 && pos_q >= archive_length) begin
						run.finish_v = 1'b1;
						run.status = ST_OK;
					end else if (idx_q == 7'd0 && (archive_length - pos_q) < 32'(HDR_BYTES)) begin
						run.finish_v = 1'b1;
						run.status = ST_TRUNC;
					end else begin
						if (idx_q == 7'd0) begin
							magic_d = 1'b1;
							nsz_d = '0;
							fsz_d = '0;
						end
						pos_d = pos_n;
						if (!is_hex(archive_byte)) begin
							run.finish_v = 1'b1;
							run.status = ST_BAD_HEX;
						end else begin
							if (idx_q < 7'd6 && archive_byte != magic_char(idx_q[2:0])) begin
								magic_d = 1'b0;
							end
							if (idx_q >= 7'd54 && idx_q <= 7'd61) begin
								fsz_d = {fsz_d[27:0], hex_value(archive_byte)};
							end
							if (idx_q >= 7'd94 && idx_q <= 7'd101) begin
								nsz_d = {nsz_d[27:0], hex_value(archive_byte)};
							end
							idx_d = idx_q + 7'd1;
							if (idx_d == HDR_BYTES) begin
								idx_d = '0;
								run.status = ST_OK;
								if (!magic_d) begin
									run.finish_v = 1'b1;
									run.status = ST_BAD_MAGIC;
								end else if (nsz_d > 32'(MAX_NAME_BYTES)) begin
									run.finish_v = 1'b1;
									run.status = ST_NAME_LONG;
								end else if (nsz_d == 32'd0) begin
									run.finish_v = 1'b1;
									run.status = ST_NAME_BAD;
								end else if (room32 < nsz_d) begin
									run.finish_v = 1'b1;
									run.status = ST_TRUNC;
								end else begin
									ncnt_d = '0;
									trl_d = 1'b1;
									phase_d = PH_NAME;
								end
							end
						end
					end
				end
				PH_NAME: begin
					run.byte_v = 1'b1;
					if (ncnt_q < NAME_CNT_W'(11) &&
						archive_byte != trailer_char(ncnt_q[3:0])) begin
						trl_d = 1'b0;
					end
					ncnt_d = ncnt_q + 1'b1;
					pos_d = pos_n;
					if (32'(ncnt_d) >= nsz_q) begin
						if (archive_byte != 8'd0) begin
							run.finish_v = 1'b1;
							run.status = ST_NAME_BAD;
						end else if (trl_d && nsz_q >= 32'd11) begin
							run.finish_v = 1'b1;
							run.status = ST_OK;
						end else if ({1'b0, fsz_q} > room) begin
							run.finish_v = 1'b1;
							run.status = ST_TOO_LARGE;
						end else begin
							run.commit_v = 1'b1;
							run.size = fsz_q;
							left_d = fsz_q;
							if (fsz_q == 32'd0 && !re[3]) begin
								run.finish_v = 1'b1;
								run.status = re[2:0];
							end else if (pos_n[1:0] != 2'd0) begin
								phase_d = PH_NAMEPAD;
							end else begin
								phase_d = (fsz_q != 32'd0) ? PH_CONTENT : PH_HEADER;
							end
						end
					end
				end
				PH_NAMEPAD: begin
					pos_d = pos_n;
					if (pos_n[1:0] == 2'd0) begin
						phase_d = (left_q != 32'd0) ? PH_CONTENT : PH_HEADER;
					end
				end
				PH_CONTENT: begin
					run.byte_v = 1'b1;
					run.is_content = 1'b1;
					pos_d = pos_n;
					left_d = left_q - 32'd1;
					if (left_d == 32'd0) begin
						if (!re[3]) begin
							run.finish_v = 1'b1;
							run.status = re[2:0];
						end else begin
							phase_d = (pos_n[1:0] != 2'd0) ? PH_CONTENTPAD : PH_HEADER;
						end
					end
				end
				PH_CONTENTPAD: begin
					pos_d = pos_n;
					if (pos_n[1:0] == 2'd0) begin
						phase_d = PH_HEADER;
					end
				end
				default: begin
				end
			endcase
			if (run.finish_v) begin
				fin_d = 1'b1;
				phase_d = PH_DONE;
			end
		end
	end

	assign run_v = take && (run.byte_v || run.commit_v || run.finish_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			pos_q <= '0;
			idx_q <= '0;
			nsz_q <= '0;
			fsz_q <= '0;
			magic_q <= 1'b1;
			ncnt_q <= '0;
			trl_q <= 1'b1;
			left_q <= '0;
			fin_q <= 1'b0;
		end else if (take) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			idx_q <= idx_d;
			nsz_q <= nsz_d;
			fsz_q <= fsz_d;
			magic_q <= magic_d;
			ncnt_q <= ncnt_d;
			trl_q <= trl_d;
			left_q <= left_d;
			fin_q <= fin_d;
		end
	end

endmodule

[rtl/cpio_queue.sv]
// ----------------------------------------------------------------------------
// cpio_queue
// Short queue of result sets between the front and the back.
// ----------------------------------------------------------------------------
module cpio_queue
	import cpio_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  run_t wr_run,
	input  logic rd,
	output run_t rd_run,
	output logic full,
	output logic empty
);

	run_t              mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wp_q;
	logic [QUEUE_AW-1:0] rp_q;
	logic [QUEUE_AW:0]   cnt_q;

	assign full = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rd_run = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wp_q] <= wr_run;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wp_q <= wp_q + 1'b1;
			end
			if (rd) begin
				rp_q <= rp_q + 1'b1;
			end
			if (wr && !rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd && !wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

[rtl/cpio_back.sv]
// ----------------------------------------------------------------------------
// cpio_back
// Unpacks the oldest result set into single result items, in order.
// ----------------------------------------------------------------------------
module cpio_back
	import cpio_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  run_t        head,
	input  logic        head_v,
	input  logic        pop,
	output logic        head_rd,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [31:0] entry_size,
	output logic [2:0]  status,
	output logic        last_of_run
);

	logic [2:0] done_q;
	logic [2:0] rem;
	logic [2:0] first;
	logic [2:0] after;

	assign rem = {head.finish_v, head.commit_v, head.byte_v} & ~done_q;
	assign first = rem & (~rem + 3'd1);
	assign after = rem & ~first;
	assign last_of_run = (after == 3'd0);
	assign head_rd = head_v && pop && last_of_run;

	always_comb begin
		kind = KIND_FINISH;
		data_byte = '0;
		entry_size = '0;
		status = head.status;
		if (first[0]) begin
			kind = head.is_content ? KIND_CONTENT : KIND_NAME;
			data_byte = head.data;
			status = ST_OK;
		end else if (first[1]) begin
			kind = KIND_COMMIT;
			entry_size = head.size;
			status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (head_v && pop) begin
			done_q <= last_of_run ? 3'd0 : (done_q | first);
		end
	end

endmodule

[rtl/cpio_archive_stream_parser.sv]
// Each result set is written into the queue when its byte is accepted.
// One byte is accepted per cycle while the queue is not full; the results of
// a byte leave one item per pop, absorbed by a four-entry queue.
// Reset (arst_n low, asynchronous): parser at a header start, queue empty.
// ----------------------------------------------------------------------------
// cpio_archive_stream_parser
// Streaming parser for crc-format (magic 070702) cpio archives, one byte per item.
// ----------------------------------------------------------------------------
module cpio_archive_stream_parser
	import cpio_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  archive_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [31:0] entry_size,
	output logic [2:0]  status,
	output logic        last_of_run
);

	logic [31:0] len_q;
	logic        take;
	run_t        run;
	logic        run_v;
	run_t        head;
	logic        head_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cfg_wr_en) begin
			len_q <= cfg_wr_data;
		end
	end

	assign take = push && !full;

	cpio_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.archive_byte(archive_byte),
		.archive_length(len_q),
		.run(run),
		.run_v(run_v)
	);

	cpio_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(run_v),
		.wr_run(run),
		.rd(head_rd),
		.rd_run(head),
		.full(full),
		.empty(empty)
	);

	cpio_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.head_v(!empty),
		.pop(pop),
		.head_rd(head_rd),
		.kind(kind),
		.data_byte(data_byte),
		.entry_size(entry_size),
		.status(status),
		.last_of_run(last_of_run)
	);

`ifndef SYNTHESIS
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty) else $error("queue full and empty at once");
	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_FINISH) |-> last_of_run)
		else $error("finish item not last of its run");
	a_commit_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_COMMIT) |-> (data_byte == 8'd0 && status == ST_OK))
		else $error("commit item carries byte or status");
`endif

endmodule
